>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the weighted time centroid block.
// The macros sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wtc_pkg.sv
// Package for the weighted time centroid block: widths, payload structs,
// controller/datapath command and status types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wtc_pkg;

  localparam int MaxIntervals = 1024;
  localparam int IdxW         = $clog2(MaxIntervals);
  localparam int VolW         = 32;
  localparam int MomW         = VolW + IdxW;
  localparam int WsumW        = 42;
  localparam int IsumW        = 52;
  localparam int StepW        = 6;
  localparam int SessW        = 11;
  localparam int NumW         = IsumW + StepW;
  localparam int DenW         = WsumW + SessW;
  localparam int RemW         = DenW + 1;
  localparam int QW           = 16;
  localparam int CentW        = QW + 1;
  localparam int DivSteps     = QW;
  localparam int CntW         = $clog2(DivSteps);
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = SessW;

  localparam logic [IdxW-1:0]    IdxMax      = IdxW'(MaxIntervals - 1);
  localparam logic [CentW-1:0]   QOne        = CentW'(1) << QW;
  localparam logic [StepW-1:0]   StepReset   = StepW'(5);
  localparam logic [SessW-1:0]   SessReset   = SessW'(389);
  localparam logic [CfgIdxW-1:0] CfgStep     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSession  = CfgIdxW'(1);

  typedef struct packed {
    logic [VolW-1:0] volume;
    logic            is_missing;
    logic            last_of_series;
  } in_t;

  typedef struct packed {
    logic [CentW-1:0] centroid;
    logic             no_weight;
  } out_t;

  typedef struct packed {
    logic capture;   // take the item, form its moment
    logic accum;     // add into the sums, advance the index
    logic prod;      // form numerator and denominator
    logic div_init;  // load the divider
    logic div_step;  // one quotient bit
    logic load_out;  // write the result register, clear the series
  } cmd_t;

  typedef struct packed {
    logic item_last;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/wtc_dp.sv
// Datapath of the weighted time centroid: config registers, sums, index,
// product stage, restoring divider and result register. Uses wtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtc_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wtc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wtc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire wtc_pkg::in_t                 in_i,
  input  wire wtc_pkg::cmd_t                cmd_i,
  output wtc_pkg::sts_t                     sts_o,
  output wtc_pkg::out_t                     out_o
);

  logic [wtc_pkg::StepW-1:0] step_q;
  logic [wtc_pkg::SessW-1:0] sess_q;
  logic [wtc_pkg::WsumW-1:0] wsum_q, wsum_d;
  logic [wtc_pkg::IsumW-1:0] isum_q, isum_d;
  logic [wtc_pkg::IdxW-1:0]  idx_q, idx_d;

  logic [wtc_pkg::VolW-1:0]  vol_q;
  logic [wtc_pkg::MomW-1:0]  mom_q;
  logic                      last_q;
  logic [wtc_pkg::NumW-1:0]  num_q;
  logic [wtc_pkg::DenW-1:0]  den_q;
  logic [wtc_pkg::RemW-1:0]  rem_q, rem_d;
  logic [wtc_pkg::QW-1:0]    quot_q, quot_d;
  logic                      sat_q, zero_q;
  wtc_pkg::out_t             out_q, out_d;

  logic [wtc_pkg::WsumW:0]   wsum_add;
  logic [wtc_pkg::IsumW:0]   isum_add;
  logic [wtc_pkg::RemW-1:0]  rem_sh;
  logic [wtc_pkg::RemW-1:0]  den_ext;

  always_comb begin
    wsum_add = {1'b0, wsum_q} + (wtc_pkg::WsumW+1)'(vol_q);
    isum_add = {1'b0, isum_q} + (wtc_pkg::IsumW+1)'(mom_q);
    // saturate on carry out
    wsum_d = wsum_add[wtc_pkg::WsumW] ? '1 : wsum_add[wtc_pkg::WsumW-1:0];
    isum_d = isum_add[wtc_pkg::IsumW] ? '1 : isum_add[wtc_pkg::IsumW-1:0];
    idx_d  = (idx_q == wtc_pkg::IdxMax) ? idx_q : idx_q + wtc_pkg::IdxW'(1);

    // remainder stays below the divisor, so the shift fits one extra bit
    den_ext = wtc_pkg::RemW'(den_q);
    rem_sh  = {rem_q[wtc_pkg::RemW-2:0], 1'b0};
    if (rem_sh >= den_ext) begin
      rem_d  = rem_sh - den_ext;
      quot_d = {quot_q[wtc_pkg::QW-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      quot_d = {quot_q[wtc_pkg::QW-2:0], 1'b0};
    end

    out_d.no_weight = (wsum_q == '0);
    if (out_d.no_weight || zero_q) begin
      out_d.centroid = '0;
    end else if (sat_q) begin
      out_d.centroid = wtc_pkg::QOne;
    end else begin
      out_d.centroid = {1'b0, quot_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= wtc_pkg::StepReset;
      sess_q <= wtc_pkg::SessReset;
      wsum_q <= '0;
      isum_q <= '0;
      idx_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          wtc_pkg::CfgStep:    step_q <= cfg_wdata_i[wtc_pkg::StepW-1:0];
          wtc_pkg::CfgSession: sess_q <= cfg_wdata_i[wtc_pkg::SessW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accum) begin
        wsum_q <= wsum_d;
        isum_q <= isum_d;
        idx_q  <= idx_d;
      end
      if (cmd_i.load_out) begin
        wsum_q <= '0;
        isum_q <= '0;
        idx_q  <= '0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      // drop missing samples: a zero addend adds nothing to either sum
      vol_q  <= in_i.is_missing ? '0 : in_i.volume;
      mom_q  <= in_i.is_missing ? '0
              : wtc_pkg::MomW'(in_i.volume) * wtc_pkg::MomW'(idx_q);
      last_q <= in_i.last_of_series;
    end
    if (cmd_i.prod) begin
      num_q <= wtc_pkg::NumW'(isum_q) * wtc_pkg::NumW'(step_q);
      den_q <= wtc_pkg::DenW'(wsum_q) * wtc_pkg::DenW'(sess_q);
    end
    if (cmd_i.div_init) begin
      sat_q  <= (num_q >= wtc_pkg::NumW'(den_q));
      zero_q <= (num_q == '0);
      rem_q  <= num_q[wtc_pkg::RemW-1:0];
      quot_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign sts_o.item_last = last_q;
  assign out_o           = out_q;

endmodule

`default_nettype wire

>>> rtl/wtc_ctrl.sv
// Controller of the weighted time centroid: sequences accumulate, product,
// divide and result load; owns the handshakes. Uses wtc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wtc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire wtc_pkg::sts_t sts_i,
  output wtc_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACCUM,
    S_PROD,
    S_INIT,
    S_DIV,
    S_OUT
  } state_e;

  state_e                   state_q, state_d;
  logic [wtc_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_free;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_free    = !out_valid_q || out_ready_i;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = sts_i.item_last ? S_PROD : S_IDLE;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_INIT;
      end
      S_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + wtc_pkg::CntW'(1);
        if (cnt_q == wtc_pkg::CntW'(wtc_pkg::DivSteps - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the result register is free
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/weighted_time_centroid.sv
// Top level of the weighted time centroid block: wires controller and
// datapath. Uses wtc_pkg, wtc_ctrl, wtc_dp and assert_macros.svh.
//
// Usage:
// - Input channel in_valid_i/in_ready_o carries one volume sample per item
//   (volume, is_missing, last_of_series). Output channel out_valid_o/
//   out_ready_i carries one result item (centroid Q1.16, no_weight) for
//   each series, after the sample marked last of series.
// - Config: cfg_we_i writes step_minutes (index 0) or session_minutes
//   (index 1) from cfg_wdata_i; write only while idle.
// - Sequence: one item is worked on at a time. A plain sample is
//   captured with the vol*index multiply, then added by the saturating
//   accumulate. A last sample then also forms the numerator and
//   denominator multiplies, loads the divider, runs the bit-serial
//   restoring divider and loads the result register, waiting while a
//   result is still untaken.
// - The result register parts the channels: a new series is accepted while
//   a result waits. If a second result is ready before the first is taken,
//   the block holds it and accepts nothing until the register frees.
// - Reset clears the sums and the index and restores step 5, session 389.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module weighted_time_centroid (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [wtc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [wtc_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire wtc_pkg::in_t                 in_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output wtc_pkg::out_t                     out_o
);

  wtc_pkg::cmd_t cmd;
  wtc_pkg::sts_t sts;

  wtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wtc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

  `ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "item overlap")
  `ASSERT_IMPL(a_rise_after_busy, $rose(out_valid_o), $past(!in_ready_o), "result while idle")
  `ASSERT_IMPL(a_centroid_range, out_valid_o, out_o.centroid <= wtc_pkg::QOne, "centroid > 1")
  `ASSERT_IMPL(a_empty_is_zero, out_valid_o && out_o.no_weight, out_o.centroid == '0,
               "empty result not zero")

endmodule

`default_nettype wire

>>> tb/sv/weighted_time_centroid_tb.sv
// Self-checking testbench for weighted_time_centroid: drives volume samples in series,
// predicts each series' centroid in SystemVerilog and compares every result item.
// Depends on wtc_pkg and the weighted_time_centroid RTL.
`timescale 1ns / 1ps

module weighted_time_centroid_tb;
  import wtc_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_t                 in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;

  // pending samples, expected centroids, idle rates
  in_t  sample_q[$];
  out_t centroid_q[$];
  int   send_idle_pct = 29;
  int   recv_idle_pct = 68;
  bit   hold_off      = 1'b0;
  bit   stall_go      = 1'b0;
  bit   in_fire       = 1'b0;
  int   n_err         = 0;
  out_t want;

  // shadow of the block's registers and series state
  logic [StepW-1:0] step_cfg   = StepReset;
  logic [SessW-1:0] sess_cfg   = SessReset;
  logic [WsumW-1:0] weight_sum = '0;
  logic [IsumW-1:0] moment_sum = '0;
  logic [IdxW-1:0]  interval   = '0;

  weighted_time_centroid DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Accumulate one accepted sample; on the last of a series, queue the centroid.
  function automatic void accumulate_sample(in_t s);
    logic [WsumW:0]      w_next;
    logic [IsumW:0]      m_next;
    logic [MomW-1:0]     moment;
    logic [79:0]         num;
    logic [79:0]         den;
    out_t                r;
    if (!s.is_missing && s.volume != '0) begin
      moment = MomW'(s.volume) * MomW'(interval);
      w_next = (WsumW+1)'(weight_sum) + (WsumW+1)'(s.volume);
      m_next = (IsumW+1)'(moment_sum) + (IsumW+1)'(moment);
      weight_sum = w_next[WsumW] ? '1 : w_next[WsumW-1:0];
      moment_sum = m_next[IsumW] ? '1 : m_next[IsumW-1:0];
    end
    if (interval != IdxMax) interval = interval + IdxW'(1);
    if (s.last_of_series) begin
      num = 80'(moment_sum) * 80'(step_cfg);
      den = 80'(sess_cfg) * 80'(weight_sum);
      r.no_weight = (weight_sum == '0);
      if (weight_sum == '0 || num == '0) begin
        r.centroid = '0;
      end else if (num >= den) begin
        // covers a zero session length as well
        r.centroid = QOne;
      end else begin
        r.centroid = CentW'((num << QW) / den);
      end
      centroid_q.push_back(r);
      weight_sum = '0;
      moment_sum = '0;
      interval   = '0;
    end
  endfunction

  // Sample the handshakes at the rising edge: predict on input, check on output.
  always @(posedge clk_i) begin
    in_fire = in_valid && in_ready;
    if (rst_ni) begin
      if (in_fire) accumulate_sample(in_data);
      if (out_valid && out_ready) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: unexpected result item centroid=%0d no_weight=%0b",
                   $time, out_data.centroid, out_data.no_weight);
          n_err++;
        end else begin
          want = centroid_q.pop_front();
          if (out_data.centroid !== want.centroid) begin
            $display("%0t: centroid expected %0d actual %0d",
                     $time, want.centroid, out_data.centroid);
            n_err++;
          end
          if (out_data.no_weight !== want.no_weight) begin
            $display("%0t: no_weight expected %0b actual %0b",
                     $time, want.no_weight, out_data.no_weight);
            n_err++;
          end
        end
      end
    end
  end

  // Sender: hold the item until accepted, then advance or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_fire)) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver stall: hold off results once stall_go is set.
  initial begin
    wait (stall_go);
    hold_off = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CfgStep) begin
      step_cfg = val[StepW-1:0];
    end else begin
      sess_cfg = val;
    end
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_scale(input int step, input int sess);
    write_reg(CfgStep, CfgDataW'(step));
    write_reg(CfgSession, CfgDataW'(sess));
  endtask

  task automatic push_sample(input logic [VolW-1:0] vol, input bit miss, input bit last);
    in_t s;
    s.volume         = vol;
    s.is_missing     = miss;
    s.last_of_series = last;
    sample_q.push_back(s);
  endtask

  // Wait until every series has reported, then let the divider go quiet.
  task automatic settle();
    while (sample_q.size() != 0 || in_valid || centroid_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  // Queue whole series of random samples until about n_items are queued.
  task automatic queue_series(input int n_items);
    int n;
    int len;
    bit miss;
    logic [VolW-1:0] vol;
    n = 0;
    while (n < n_items) begin
      case ($urandom_range(19))
        0:       len = $urandom_range(41, 200);
        1, 2, 3: len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(9))
          0:       vol = '0;
          1:       vol = '1;
          2, 3, 4: vol = $urandom;
          default: vol = $urandom_range(5000);
        endcase
        miss = ($urandom_range(99) < 12);
        push_sample(vol, miss, k == len - 1);
      end
      n += len;
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed series under the reset scaling
    push_sample('0, 1'b0, 1'b1);
    push_sample('1, 1'b1, 1'b0);
    push_sample(32'd123, 1'b1, 1'b1);
    push_sample('1, 1'b0, 1'b1);
    push_sample('0, 1'b0, 1'b0);
    push_sample('1, 1'b0, 1'b1);
    push_sample(32'd1, 1'b0, 1'b0);
    push_sample('0, 1'b0, 1'b0);
    push_sample(32'd7, 1'b1, 1'b0);
    push_sample(32'd1, 1'b0, 1'b1);
    push_sample(32'h8000_0001, 1'b0, 1'b0);
    push_sample(32'h7FFF_FFFE, 1'b0, 1'b1);
    settle();

    // upper data bits set, step field zero: numerator vanishes
    write_reg(CfgStep, CfgDataW'(11'h7C0));
    push_sample(32'd5, 1'b0, 1'b0);
    push_sample(32'd9, 1'b0, 1'b1);
    settle();

    // zero session clamps to one unless the moment is zero
    set_scale(60, 0);
    push_sample(32'd3, 1'b0, 1'b0);
    push_sample(32'd4, 1'b0, 1'b1);
    push_sample(32'd4, 1'b0, 1'b1);
    settle();

    set_scale(63, 1);
    push_sample('0, 1'b0, 1'b0);
    push_sample(32'd1, 1'b0, 1'b1);
    settle();

    set_scale(1, 2047);
    push_sample(32'd1, 1'b0, 1'b0);
    push_sample(32'd1, 1'b0, 1'b1);
    settle();

    // random series, then stall the result side so the block backs up
    set_scale($urandom_range(1, 60), $urandom_range(1, 1440));
    queue_series(50);
    stall_go = 1'b1;
    settle();

    send_idle_pct = 68;
    recv_idle_pct = 29;
    set_scale(63, 2047);
    queue_series(30);
    settle();
    set_scale($urandom_range(1, 60), $urandom_range(1, 1440));
    queue_series(20);
    settle();

    // one long series: the index and the weight sum saturate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_scale(1, 1440);
    for (int k = 0; k < 1030; k++) begin
      if (k == 300) begin
        push_sample($urandom, 1'b1, 1'b0);
      end else if (k == 700) begin
        push_sample($urandom, 1'b0, 1'b0);
      end else begin
        push_sample('1, 1'b0, k == 1029);
      end
    end
    queue_series(20);
    settle();

    set_scale(60, 1);
    queue_series(20);
    settle();

    if (n_err == 0 && centroid_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
